// ===== rtl/rrca_pkg.sv =====
// Shared types and constants for the reorder receiver with cumulative ack.
package rrca_pkg;

  // Default configuration
  localparam int DEF_WINDOW      = 32;
  localparam int DEF_MAX_PAYLOAD = 1024;

  // Field widths
  localparam int SEQ_W = 16;
  localparam int LEN_W = 11;
  localparam int HDL_W = 16;

  // Result kinds
  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  // Incoming packet descriptor
  typedef struct packed {
    logic [SEQ_W-1:0] seq_num;
    logic [LEN_W-1:0] payload_len;
    logic             last_flag;
    logic [HDL_W-1:0] payload_handle;
  } rrca_in_t;

  // Outgoing result beat
  typedef struct packed {
    logic             kind;
    logic [SEQ_W-1:0] number;
    logic [LEN_W-1:0] length;
    logic [HDL_W-1:0] handle;
    logic             last_mark;
    logic             end_of_run;
  } rrca_out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clr_step;  // clear one valid bit of the reset sweep
    logic latch;     // capture the accepted descriptor
    logic store;     // write the descriptor into its slot
    logic rd;        // read the slot of the expected number
    logic deliver;   // send the read slot downstream and advance
    logic emit_ack;  // send an acknowledgement
    logic ack_dec;   // acknowledge expected minus one
  } rrca_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_done;    // last entry of the reset sweep
    logic finished;    // transfer is over
    logic in_window;   // descriptor lies in the receive window
    logic in_order;    // descriptor is the expected one
    logic rd_hit;      // read slot is valid with nonzero length
    logic rd_last;     // read slot ends the transfer
    logic last_drain;  // this delivery reaches the per-packet drain bound
    logic out_free;    // output register can take a beat
  } rrca_stat_t;

endpackage

// ===== rtl/rrca_ifs.sv =====
// Valid/ready channel interfaces for descriptors and result beats.
interface rrca_in_if import rrca_pkg::*; ();
  logic     valid;
  logic     ready;
  rrca_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rrca_out_if import rrca_pkg::*; ();
  logic      valid;
  logic      ready;
  rrca_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/rrca_ctrl.sv =====
// Sequencing state machine of the reorder receiver.
module rrca_ctrl import rrca_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  rrca_stat_t stat_i,
  output rrca_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_EVAL  = 6'b000100,
    S_READ  = 6'b001000,
    S_CHECK = 6'b010000,
    S_ACK   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   ack_dec_q, ack_dec_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d   = state_q;
    ack_dec_d = ack_dec_q;
    cmd_o     = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EVAL;
        end
      end
      S_EVAL: begin
        priority if (stat_i.finished) begin
          state_d = S_IDLE;
        end else if (!stat_i.in_window) begin
          ack_dec_d = 1'b0;
          state_d   = S_ACK;
        end else begin
          cmd_o.store = 1'b1;
          if (stat_i.in_order) begin
            state_d = S_READ;
          end else begin
            ack_dec_d = 1'b0;
            state_d   = S_ACK;
          end
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_CHECK;
      end
      S_CHECK: begin
        priority if (!stat_i.rd_hit) begin
          ack_dec_d = 1'b1;
          state_d   = S_ACK;
        end else if (stat_i.out_free) begin
          cmd_o.deliver = 1'b1;
          priority if (stat_i.rd_last) begin
            state_d = S_IDLE;
          end else if (stat_i.last_drain) begin
            ack_dec_d = 1'b1;
            state_d   = S_ACK;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_ACK: begin
        cmd_o.ack_dec = ack_dec_q;
        if (stat_i.out_free) begin
          cmd_o.emit_ack = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      ack_dec_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ack_dec_q <= ack_dec_d;
    end
  end

  // Accept only after the sweep, never emit two kinds of beat at once, and store only a fresh descriptor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.latch |-> $past(rst_ni) && !cmd_o.clr_step)
    else $error("descriptor taken during reset sweep");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.deliver && cmd_o.emit_ack))
    else $error("delivery and ack issued together");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.store |-> $past(cmd_o.latch))
    else $error("slot written without a fresh descriptor");

endmodule

// ===== rtl/rrca_dpath.sv =====
// Slot storage, sequence tracking and output register of the receiver.
module rrca_dpath import rrca_pkg::*; #(
  parameter int WINDOW      = DEF_WINDOW,
  parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  rrca_in_t   in_data_i,
  input  rrca_cmd_t  cmd_i,
  output rrca_stat_t stat_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output rrca_out_t  out_data_o
);

  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(WINDOW - 1);
  localparam logic [IDX_W:0]   WinExt  = (IDX_W + 1)'(WINDOW);
  localparam logic [SEQ_W-1:0] WinSeq  = SEQ_W'(WINDOW);
  localparam logic [15:0]      MaxPay  = 16'(MAX_PAYLOAD);

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             last;
    logic [HDL_W-1:0] hdl;
  } slot_t;

  // Slot memories
  logic  v_mem [WINDOW];
  slot_t p_mem [WINDOW];

  // Captured descriptor
  logic [SEQ_W-1:0] seq_q;
  logic [LEN_W-1:0] len_q;
  logic             last_q;
  logic [HDL_W-1:0] hdl_q;

  // Sequence state
  logic [SEQ_W-1:0] exp_q;
  logic [IDX_W-1:0] exp_slot_q;
  logic             fin_q;
  logic [IDX_W-1:0] cnt_q;
  logic [IDX_W-1:0] clr_idx_q;

  // Read data
  logic  rd_valid_q;
  slot_t rd_q;

  // Output register
  logic      out_valid_q;
  rrca_out_t out_q;

  logic [SEQ_W-1:0] seq_gap;
  logic             wrapped;
  logic [IDX_W:0]   sum;
  logic [IDX_W:0]   sum_red;
  logic [IDX_W-1:0] in_slot;
  logic [LEN_W-1:0] len_sat;
  logic             v_we;
  logic [IDX_W-1:0] v_wa;
  logic             v_wd;
  logic             advance;

  // Saturate the length at capture
  assign len_sat = ({5'b0, in_data_i.payload_len} > MaxPay) ? MaxPay[LEN_W-1:0]
                                                            : in_data_i.payload_len;

  // Window distance and slot of the captured number; a number that wrapped
  // past zero is below the window size and is its own slot
  assign seq_gap = seq_q - exp_q;
  assign wrapped = (seq_q < exp_q);
  assign sum     = {1'b0, exp_slot_q} + {1'b0, seq_gap[IDX_W-1:0]};
  assign sum_red = (sum >= WinExt) ? (sum - WinExt) : sum;
  assign in_slot = wrapped ? seq_q[IDX_W-1:0] : sum_red[IDX_W-1:0];

  assign advance = cmd_i.deliver && !rd_q.last;

  // Status
  assign stat_o.clr_done   = (clr_idx_q == LastIdx);
  assign stat_o.finished   = fin_q;
  assign stat_o.in_window  = (seq_gap < WinSeq);
  assign stat_o.in_order   = (seq_gap == '0);
  assign stat_o.rd_hit     = rd_valid_q && (rd_q.len != '0);
  assign stat_o.rd_last    = rd_q.last;
  assign stat_o.last_drain = (cnt_q == LastIdx);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  // Capture the accepted descriptor
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      seq_q  <= in_data_i.seq_num;
      len_q  <= len_sat;
      last_q <= in_data_i.last_flag;
      hdl_q  <= in_data_i.payload_handle;
    end
  end

  // Valid-bit write port: sweep, store or clear on a delivery that is not the last
  always_comb begin
    v_we = 1'b0;
    v_wa = exp_slot_q;
    v_wd = 1'b0;
    priority if (cmd_i.clr_step) begin
      v_we = 1'b1;
      v_wa = clr_idx_q;
    end else if (cmd_i.store) begin
      v_we = 1'b1;
      v_wa = in_slot;
      v_wd = 1'b1;
    end else if (advance) begin
      v_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v_we) v_mem[v_wa] <= v_wd;
  end

  // Payload write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) p_mem[in_slot] <= '{len: len_q, last: last_q, hdl: hdl_q};
  end

  // Registered read of the expected slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_valid_q <= v_mem[exp_slot_q];
      rd_q       <= p_mem[exp_slot_q];
    end
  end

  // Sweep index, expected number, drain count and finish flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q  <= '0;
      exp_q      <= '0;
      exp_slot_q <= '0;
      cnt_q      <= '0;
      fin_q      <= 1'b0;
    end else begin
      if (cmd_i.clr_step) clr_idx_q <= clr_idx_q + 1'b1;
      if (cmd_i.latch) cnt_q <= '0;
      if (cmd_i.deliver && rd_q.last) fin_q <= 1'b1;
      if (advance) begin
        exp_q <= exp_q + 1'b1;
        cnt_q <= cnt_q + 1'b1;
        if ((exp_q == '1) || (exp_slot_q == LastIdx)) begin
          exp_slot_q <= '0;
        end else begin
          exp_slot_q <= exp_slot_q + 1'b1;
        end
      end
    end
  end

  // Output register: load a beat, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.deliver || cmd_i.emit_ack) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.deliver) begin
      out_q <= '{kind: KIND_DELIVER, number: exp_q, length: rd_q.len,
                 handle: rd_q.hdl, last_mark: rd_q.last, end_of_run: rd_q.last};
    end else if (cmd_i.emit_ack) begin
      out_q <= '{kind: KIND_ACK, number: cmd_i.ack_dec ? (exp_q - 1'b1) : exp_q,
                 length: '0, handle: '0, last_mark: last_q, end_of_run: 1'b1};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Delivering the last packet ends the transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.deliver && rd_q.last) |=> fin_q)
    else $error("last delivery did not finish the transfer");
  // A waiting beat is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !(cmd_i.deliver || cmd_i.emit_ack))
    else $error("output beat overwritten while stalled");
  // Delivery only from a hit on a valid slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.deliver |-> rd_valid_q && (rd_q.len != '0) && !fin_q)
    else $error("delivery from an empty slot");

endmodule

// ===== rtl/reorder_receiver_cumulative_ack.sv =====
// Top level of the reorder receiver with cumulative acknowledgement.
// Receiver side of a reliable datagram transfer: each descriptor beat on in_i
// is either acked (out of window or out of order, ack number = expected) or,
// when it is the expected one, followed by in-order delivery beats of it and
// the stored packets that follow it without a gap, then an ack of expected
// minus one; delivering the last packet ends the transfer and later
// descriptors are dropped without result. After reset the slot valid bits
// are swept clear before the first descriptor is taken. One descriptor is
// worked at a time by the sequencer: a descriptor dropped after the transfer
// has ended is latched and evaluated, an acked-only one is also acked, and
// an in-order one gets one registered slot read and one check per visited
// slot, the last visit being the miss that stops the drain. A drain that
// reaches the bound of WINDOW deliveries skips that final miss; delivering
// the last packet skips the ack. Stalls on the output side hold the
// sequencer in its check or ack state.
module reorder_receiver_cumulative_ack import rrca_pkg::*; #(
  parameter int WINDOW      = DEF_WINDOW,
  parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rrca_in_if.sink           in_i,
  rrca_out_if.source        out_o
);

  rrca_cmd_t  cmd;
  rrca_stat_t stat;
  logic       in_ready;

  rrca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rrca_dpath #(
    .WINDOW      (WINDOW),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_i.data),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

  assign in_i.ready = in_ready;

endmodule

// ===== dv/reorder_receiver_cumulative_ack_tb.sv =====
// Self-checking testbench for the reorder receiver with cumulative ack.
`timescale 1ns / 100ps

module reorder_receiver_cumulative_ack_tb import rrca_pkg::*; ();

  localparam int WINDOW      = DEF_WINDOW;
  localparam int MAX_PAYLOAD = DEF_MAX_PAYLOAD;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int CALM_ITEMS  = 60;
  localparam int TAIL_CYCLES = 100;

  typedef struct {
    rrca_in_t pkt;
    bit       wait_drain;
  } tx_item_t;

  logic clk_i;
  logic rst_ni;

  rrca_in_if  in_if ();
  rrca_out_if out_if ();

  reorder_receiver_cumulative_ack #(
    .WINDOW      (WINDOW),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Descriptor beats waiting to be sent, and results waiting to come out
  tx_item_t  tx_q[$];
  rrca_out_t results_due[$];

  // Receiver state mirrored by the predictor
  logic [SEQ_W-1:0] rx_expected;
  logic             xfer_done;
  logic             slot_full [WINDOW];
  logic [LEN_W-1:0] slot_len  [WINDOW];
  logic             slot_end  [WINDOW];
  logic [HDL_W-1:0] slot_hdl  [WINDOW];

  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned stuck_cycles;
  int unsigned tx_gap;
  int unsigned rx_stall;
  int unsigned hold_left;
  bit          hold_done;
  bit          drained;
  bit          sent_all;
  bit          calm;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Work out the beats one descriptor causes and update the mirrored state
  function automatic void predict_packet(input rrca_in_t pkt);
    logic [SEQ_W-1:0] gap;
    logic [LEN_W-1:0] len;
    int unsigned      idx;
    int unsigned      n_del;
    rrca_out_t        ack;
    rrca_out_t        dlv;
    if (xfer_done) return;
    gap = pkt.seq_num - rx_expected;
    ack = '0;
    ack.kind       = KIND_ACK;
    ack.last_mark  = pkt.last_flag;
    ack.end_of_run = 1'b1;
    // out of window: ack only
    if (gap >= WINDOW) begin
      ack.number = rx_expected;
      results_due.push_back(ack);
      return;
    end
    len = (pkt.payload_len > MAX_PAYLOAD) ? LEN_W'(MAX_PAYLOAD) : pkt.payload_len;
    idx = pkt.seq_num % WINDOW;
    slot_full[idx] = 1'b1;
    slot_len[idx]  = len;
    slot_end[idx]  = pkt.last_flag;
    slot_hdl[idx]  = pkt.payload_handle;
    if (gap != 0) begin
      ack.number = rx_expected;
      results_due.push_back(ack);
      return;
    end
    // drain stored slots in order, at most one window per descriptor
    for (n_del = 0; n_del < WINDOW; n_del++) begin
      idx = rx_expected % WINDOW;
      if (!slot_full[idx] || slot_len[idx] == 0) break;
      dlv = '0;
      dlv.kind      = KIND_DELIVER;
      dlv.number    = rx_expected;
      dlv.length    = slot_len[idx];
      dlv.handle    = slot_hdl[idx];
      dlv.last_mark = slot_end[idx];
      if (slot_end[idx]) begin
        dlv.end_of_run = 1'b1;
        xfer_done = 1'b1;
        results_due.push_back(dlv);
        return;
      end
      results_due.push_back(dlv);
      slot_full[idx] = 1'b0;
      rx_expected++;
    end
    ack.number = rx_expected - 1'b1;
    results_due.push_back(ack);
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: beat %0d field %s expected 0x%0h, got 0x%0h",
               $time, results_seen, name, want, got);
      mismatches++;
    end
  endtask

  task automatic queue_pkt(input logic [SEQ_W-1:0] seq, input logic [LEN_W-1:0] len,
                           input logic last, input logic [HDL_W-1:0] hdl);
    tx_item_t item;
    item.pkt.seq_num        = seq;
    item.pkt.payload_len    = len;
    item.pkt.last_flag      = last;
    item.pkt.payload_handle = hdl;
    item.wait_drain         = 1'b0;
    tx_q.push_back(item);
  endtask

  function automatic logic [LEN_W-1:0] rand_len();
    if ($urandom_range(0, 7) == 0) return LEN_W'($urandom_range(MAX_PAYLOAD + 1, 2047));
    return LEN_W'($urandom_range(1, MAX_PAYLOAD));
  endfunction

  // A batch of packets [base, base+span) in random order, with
  // zero-length copies ahead of the real ones, repeats and stray numbers.
  task automatic queue_batch(input logic [SEQ_W-1:0] base, input int unsigned span,
                             input bit closing, input bit drain_first);
    logic [SEQ_W-1:0] order[$];
    logic [SEQ_W-1:0] tmp;
    logic [SEQ_W-1:0] stray;
    logic [SEQ_W-1:0] top;
    int unsigned      j;
    int unsigned      pick;
    int unsigned      mark;
    mark = tx_q.size();
    top  = base + SEQ_W'(span - 1);
    for (j = 0; j < span; j++) order.push_back(base + SEQ_W'(j));
    for (j = span - 1; j > 0; j--) begin
      pick = $urandom_range(0, j);
      tmp = order[j];
      order[j] = order[pick];
      order[pick] = tmp;
    end
    // full window: send the expected one last so the whole window drains at once
    if (span == WINDOW) begin
      for (j = 0; j < span; j++) begin
        if (order[j] == base) begin
          order[j] = order[span-1];
          order[span-1] = base;
        end
      end
    end
    for (j = 0; j < span; j++) begin
      case ($urandom_range(0, 11))
        0: begin
          do stray = SEQ_W'($urandom); while (SEQ_W'(stray - base) < span + WINDOW);
          queue_pkt(stray, LEN_W'($urandom), 1'($urandom), HDL_W'($urandom));
        end
        1: queue_pkt(base - SEQ_W'($urandom_range(1, 40)), rand_len(), 1'($urandom),
                     HDL_W'($urandom));
        2: begin
          if (j != 0) begin
            pick = $urandom_range(0, j - 1);
            if (!(closing && order[pick] == top))
              queue_pkt(order[pick], rand_len(), 1'b0, HDL_W'($urandom));
          end
        end
        default: ;
      endcase
      if ($urandom_range(0, 4) == 0)
        queue_pkt(order[j], '0, 1'($urandom), HDL_W'($urandom));
      queue_pkt(order[j], rand_len(), closing && order[j] == top, HDL_W'($urandom));
    end
    if (drain_first) tx_q[mark].wait_drain = 1'b1;
  endtask

  // Stimulus and end of run
  initial begin
    logic [SEQ_W-1:0] next_base;
    int unsigned      span;
    int unsigned      batches;
    rst_ni = 1'b0;

    // zero length at expected, out of order, saturation, window edges
    queue_pkt(16'd0, 11'd0, 1'b0, 16'h0000);
    queue_pkt(16'd2, 11'd7, 1'b0, 16'hFFFF);
    queue_pkt(16'd1, 11'd2047, 1'b0, 16'h1234);
    queue_pkt(16'd0, 11'd0, 1'b1, 16'h5555);
    queue_pkt(16'd32, 11'd1, 1'b0, 16'h00FF);
    queue_pkt(16'd31, 11'd1024, 1'b0, 16'h0000);
    queue_pkt(16'hFFFF, 11'd3, 1'b1, 16'hAAAA);
    // expected arrives: drain 0..2
    queue_pkt(16'd0, 11'd1025, 1'b0, 16'hABCD);
    queue_pkt(16'd3, 11'd1, 1'b0, 16'h0F0F);
    // already delivered, far away
    queue_pkt(16'd2, 11'd5, 1'b0, 16'h1111);
    queue_pkt(16'h8000, 11'd1024, 1'b0, 16'h8000);
    // zero-length last stored ahead, stops the drain until repaired
    queue_pkt(16'd5, 11'd0, 1'b1, 16'h2222);
    queue_pkt(16'd4, 11'd100, 1'b0, 16'h3333);
    queue_pkt(16'd5, 11'd200, 1'b0, 16'h4444);

    next_base = 16'd6;
    batches = 0;
    while (tx_q.size() < 440) begin
      span = ($urandom_range(0, 9) == 0) ? WINDOW : $urandom_range(1, 12);
      queue_batch(next_base, span, 1'b0, batches % 9 == 1);
      next_base += SEQ_W'(span);
      batches++;
    end
    queue_batch(next_base, $urandom_range(3, 10), 1'b1, 1'b1);
    // transfer is over: these are dropped
    repeat (4) queue_pkt(SEQ_W'($urandom), rand_len(), 1'($urandom), HDL_W'($urandom));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i); while (!(sent_all && drained));
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("reorder_receiver_cumulative_ack_tb passed");
    else $display("reorder_receiver_cumulative_ack_tb failed");
    $finish;
  end

  // Descriptor driver: hold a beat until taken, idle in random bursts
  always @(posedge clk_i or negedge rst_ni) begin
    logic took;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
      tx_gap      <= 0;
      sent_all    <= 1'b0;
      calm        <= 1'b0;
    end else begin
      took = in_if.valid && in_if.ready;
      if (took) void'(tx_q.pop_front());
      sent_all <= (tx_q.size() == 0);
      calm     <= (tx_q.size() < CALM_ITEMS);
      if (in_if.valid && !took) begin
        // hold the beat
      end else if (tx_gap != 0) begin
        in_if.valid <= 1'b0;
        tx_gap      <= tx_gap - 1;
      end else if (tx_q.size() != 0 && (!tx_q[0].wait_drain || (drained && !took))) begin
        if (!calm && $urandom_range(0, 5) == 0) begin
          in_if.valid <= 1'b0;
          tx_gap      <= $urandom_range(0, 7);
        end else begin
          in_if.valid <= 1'b1;
          in_if.data  <= tx_q[0].pkt;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result ready: random stall bursts and one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_stall     <= 0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!hold_done && results_seen >= 150) begin
      out_if.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES - 1;
      hold_done    <= 1'b1;
    end else if (rx_stall != 0) begin
      out_if.ready <= 1'b0;
      rx_stall     <= rx_stall - 1;
    end else if (!calm && $urandom_range(0, 6) == 0) begin
      out_if.ready <= 1'b0;
      rx_stall     <= $urandom_range(0, 7);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Monitor: predict on each descriptor beat, check each result beat
  always @(posedge clk_i or negedge rst_ni) begin
    rrca_out_t want;
    if (!rst_ni) begin
      rx_expected = '0;
      xfer_done   = 1'b0;
      for (int i = 0; i < WINDOW; i++) begin
        slot_full[i] = 1'b0;
        slot_len[i]  = '0;
        slot_end[i]  = 1'b0;
        slot_hdl[i]  = '0;
      end
      drained      <= 1'b1;
      results_seen <= 0;
    end else begin
      if (in_if.valid && in_if.ready) predict_packet(in_if.data);
      if (out_if.valid && out_if.ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got 0x%0h", $time, out_if.data);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          check_field("kind", want.kind, out_if.data.kind);
          check_field("number", want.number, out_if.data.number);
          check_field("length", want.length, out_if.data.length);
          check_field("handle", want.handle, out_if.data.handle);
          check_field("last_mark", want.last_mark, out_if.data.last_mark);
          check_field("end_of_run", want.end_of_run, out_if.data.end_of_run);
        end
        results_seen <= results_seen + 1;
      end
      drained <= (results_due.size() == 0);
    end
  end

  // Watchdog: end the run if no beat moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stuck_cycles <= 0;
    end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STALL_LIMIT) begin
      $display("reorder_receiver_cumulative_ack_tb failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule
